@@ rtl/tbpf_pkg.sv @@
// tbpf_pkg: shared constants and helpers of the tile background pixel fetch
// video memory geometry, tile map bases, lcd control bits and shade colours
// no dependencies
package tbpf_pkg;

    localparam int VRAM_DEPTH = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int VRAM_DW    = 8;

    localparam logic [VRAM_AW-1:0] MAP_LOW_BASE  = 13'h1800;
    localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE = 13'h1c00;

    // lcd control bit positions
    localparam int LCDC_DISPLAY_ON  = 7;
    localparam int LCDC_TILE_UNSIGN = 4;
    localparam int LCDC_MAP_HIGH    = 3;
    localparam int LCDC_BG_ON       = 0;

    // configuration register indexes
    localparam logic [1:0] REG_LCD_CONTROL = 2'd0;
    localparam logic [1:0] REG_HSCROLL     = 2'd1;
    localparam logic [1:0] REG_VSCROLL     = 2'd2;
    localparam logic [1:0] REG_PALETTE     = 2'd3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [31:0] ARGB_SHADE0 = 32'hffffffff;
    localparam logic [31:0] ARGB_SHADE1 = 32'hffaaaaaa;
    localparam logic [31:0] ARGB_SHADE2 = 32'hff888888;
    localparam logic [31:0] ARGB_SHADE3 = 32'hff000000;

    function automatic logic [31:0] shade_to_argb(input logic [1:0] shade);
        logic [31:0] argb;
        case (shade)
            2'd0:    argb = ARGB_SHADE0;
            2'd1:    argb = ARGB_SHADE1;
            2'd2:    argb = ARGB_SHADE2;
            2'd3:    argb = ARGB_SHADE3;
            default: argb = ARGB_SHADE0;
        endcase
        return argb;
    endfunction

endpackage

@@ rtl/tbpf_ram.sv @@
// tbpf_ram: generic single write port, single read port ram
// registered read data; no dependencies
module tbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tile_background_pixel_fetch.sv @@
// tile_background_pixel_fetch: background pixel fetcher with 8 KiB video memory
// depends on tbpf_pkg and tbpf_ram
//
// usage
// - request channel (req_valid / req_stall): one transfer is either a video
//   memory byte write (req_type 0) or a screen pixel fetch (req_type 1)
// - result channel (res_valid / res_stall): one transfer per pixel fetch,
//   carrying shade, argb and the echoed pixel position
// - apb port: lcd control, horizontal scroll, vertical scroll and background
//   palette at 0x0/0x4/0x8/0xc; the user must see that they are written only
//   while the block is idle, the block does not enforce it; pready is always high
// - a write lands in video memory at its transfer edge
// - a pixel fetch steps through the single video memory read port: tile map
//   read, low bitplane read, high bitplane read, then the result is loaded
//   into the output register, which raises res_valid
// - req_stall is high while a fetch is in flight, so writes are taken at one
//   per cycle only while idle, and a new fetch waits until the last has loaded its result
// - the output register lets a new request be taken while a result waits;
//   a fetch that finishes while the receiver stalls holds in its last step
// - reset clears the configuration registers, result valid flag and sequencer;
//   video memory holds no reset value and must be written before it is read
module tile_background_pixel_fetch (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [12:0] mem_addr,
    input  logic [7:0]  mem_data,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  shade,
    output logic [31:0] argb,
    output logic [7:0]  out_x,
    output logic [7:0]  out_y,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD_MAP = 3'd1;
    localparam logic [2:0] S_RD_LO  = 3'd2;
    localparam logic [2:0] S_RD_HI  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam int AW = tbpf_pkg::VRAM_AW;
    localparam int DW = tbpf_pkg::VRAM_DW;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [7:0] lcd_control_reg;
    logic [7:0] hscroll_reg;
    logic [7:0] vscroll_reg;
    logic [7:0] palette_reg;

    // fetch context
    logic [7:0]  px_reg, py_reg;
    logic [7:0]  bx_reg, by_reg;
    logic [7:0]  tile_reg;
    logic [DW-1:0] lo_reg;

    // output register
    logic        res_valid_reg;
    logic [1:0]  shade_reg;
    logic [31:0] argb_reg;
    logic [7:0]  out_x_reg, out_y_reg;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic req_xfer;
    logic res_xfer;
    logic cfg_write;
    logic out_load;
    logic bg_enable;
    logic [2:0] bit_sel;
    logic [1:0] colour;
    logic [1:0] shade_calc;
    logic [AW-1:0] map_base;

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign res_xfer  = res_valid_reg && !res_stall;
    assign ram_we    = req_xfer && (req_type == tbpf_pkg::REQ_WRITE);

    // the output register is free when empty or being emptied this cycle
    assign out_load = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    // apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            tbpf_pkg::REG_LCD_CONTROL: prdata = {24'd0, lcd_control_reg};
            tbpf_pkg::REG_HSCROLL:     prdata = {24'd0, hscroll_reg};
            tbpf_pkg::REG_VSCROLL:     prdata = {24'd0, vscroll_reg};
            tbpf_pkg::REG_PALETTE:     prdata = {24'd0, palette_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_control_reg <= 8'd0;
            hscroll_reg     <= 8'd0;
            vscroll_reg     <= 8'd0;
            palette_reg     <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                tbpf_pkg::REG_LCD_CONTROL: lcd_control_reg <= pwdata[7:0];
                tbpf_pkg::REG_HSCROLL:     hscroll_reg     <= pwdata[7:0];
                tbpf_pkg::REG_VSCROLL:     vscroll_reg     <= pwdata[7:0];
                tbpf_pkg::REG_PALETTE:     palette_reg     <= pwdata[7:0];
                default:                   ;
            endcase
        end
    end

    // background on only with display, background and unsigned tile data set
    assign bg_enable = lcd_control_reg[tbpf_pkg::LCDC_DISPLAY_ON]
                    && lcd_control_reg[tbpf_pkg::LCDC_BG_ON]
                    && lcd_control_reg[tbpf_pkg::LCDC_TILE_UNSIGN];

    assign map_base = lcd_control_reg[tbpf_pkg::LCDC_MAP_HIGH]
                    ? tbpf_pkg::MAP_HIGH_BASE : tbpf_pkg::MAP_LOW_BASE;

    // read address per step; the tile number arrives from the ram in S_RD_LO
    // the high bitplane address is held in S_DONE so a stalled result keeps it
    always_comb
    begin
        case (state_reg)
            S_RD_MAP:        ram_raddr = map_base + {3'd0, by_reg[7:3], bx_reg[7:3]};
            S_RD_LO:         ram_raddr = {1'b0, ram_rdata, by_reg[2:0], 1'b0};
            S_RD_HI, S_DONE: ram_raddr = {1'b0, tile_reg, by_reg[2:0], 1'b1};
            default:         ram_raddr = '0;
        endcase
    end

    // in S_DONE the ram returns the high bitplane byte; bit 7 is leftmost
    assign bit_sel    = 3'd7 - bx_reg[2:0];
    assign colour     = {ram_rdata[bit_sel], lo_reg[bit_sel]};
    assign shade_calc = bg_enable ? palette_reg[{colour, 1'b0} +: 2] : 2'd0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer && (req_type == tbpf_pkg::REQ_PIXEL))
                begin
                    state_next = S_RD_MAP;
                end
            end
            S_RD_MAP: state_next = S_RD_LO;
            S_RD_LO:  state_next = S_RD_HI;
            S_RD_HI:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_xfer)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer && (req_type == tbpf_pkg::REQ_PIXEL))
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
            bx_reg <= pixel_x + hscroll_reg;
            by_reg <= pixel_y + vscroll_reg;
        end
        if (state_reg == S_RD_LO)
        begin
            tile_reg <= ram_rdata;
        end
        if (state_reg == S_RD_HI)
        begin
            lo_reg <= ram_rdata;
        end
        if (out_load)
        begin
            shade_reg <= shade_calc;
            argb_reg  <= tbpf_pkg::shade_to_argb(shade_calc);
            out_x_reg <= px_reg;
            out_y_reg <= py_reg;
        end
    end

    tbpf_ram #(
        .WIDTH (DW),
        .DEPTH (tbpf_pkg::VRAM_DEPTH)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (mem_addr),
        .wdata (mem_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_valid = res_valid_reg;
    assign shade     = shade_reg;
    assign argb      = argb_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    // a result only appears at the end of a fetch
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result appeared outside the final fetch step");

    // memory writes never overlap a fetch in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("video memory write during a fetch");

    // the three reads follow one another without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_MAP) |=> (state_reg == S_RD_LO) ##1 (state_reg == S_RD_HI))
        else $error("fetch read sequence broken");

    // a finished fetch waits only while a stalled result occupies the output
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !(res_valid_reg && res_stall)) |=> res_valid_reg)
        else $error("finished fetch not loaded into the output register");

endmodule

@@ dv/tb_tile_background_pixel_fetch.sv @@
// testbench for tile_background_pixel_fetch: directed plan, then random phases
// predicts each pixel from its own copy of video memory and registers; uses tbpf_pkg
`timescale 1ns / 1ps

module tb_tile_background_pixel_fetch;

    localparam int ITEM_TARGET   = 1050;
    localparam int QUIET_FROM    = 920;   // no idling on either side after this many transfers
    localparam int SETTLE_CYCLES = 8;     // margin for the pipe to empty after the last result
    localparam int STALL_LIMIT   = 500;   // cycles without any transfer before giving up

    // one expected pixel result
    typedef struct packed {
        logic [1:0]  shade;
        logic [31:0] argb;
        logic [7:0]  x;
        logic [7:0]  y;
    } pixel_t;

    // directed plan: register write, memory write or pixel fetch
    typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [12:0] addr;      // memory address, or register index for ROW_CFG
        logic [7:0]  data;
        logic [7:0]  x;
        logic [7:0]  y;
        bit          typed;     // pixel result spelled out in the row
        pixel_t      want;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        req_type  = tbpf_pkg::REQ_WRITE;
    logic [12:0] mem_addr  = '0;
    logic [7:0]  mem_data  = '0;
    logic [7:0]  pixel_x   = '0;
    logic [7:0]  pixel_y   = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  shade;
    logic [31:0] argb;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    tile_background_pixel_fetch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .mem_addr  (mem_addr),
        .mem_data  (mem_data),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .shade     (shade),
        .argb      (argb),
        .out_x     (out_x),
        .out_y     (out_y),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // shadow of the block: video memory, which bytes hold data, registers
    // ---------------------------------------------------------------
    logic [7:0]  video_mem   [tbpf_pkg::VRAM_DEPTH];
    bit          mem_written [tbpf_pkg::VRAM_DEPTH];
    logic [7:0]  lcdc_q = '0;
    logic [7:0]  scx_q  = '0;
    logic [7:0]  scy_q  = '0;
    logic [7:0]  pal_q  = '0;
    logic [31:0] shade_colour [4] = '{tbpf_pkg::ARGB_SHADE0, tbpf_pkg::ARGB_SHADE1,
                                      tbpf_pkg::ARGB_SHADE2, tbpf_pkg::ARGB_SHADE3};

    pixel_t      pending_pixels [$];   // fetched pixels whose result transfer is still due
    plan_row_t   plan [$];
    pixel_t      oldest;

    int          errors      = 0;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          smooth      = 1'b0;   // phase with no idling on either side
    bit          quiet       = 1'b0;   // tail of the run, no idling at all

    // tile map byte for a screen position, scroll added and wrapped at 256
    function automatic logic [12:0] map_entry_addr(logic [7:0] x, logic [7:0] y);
        logic [7:0]  bx;
        logic [7:0]  by;
        logic [12:0] base;
        bx = x + scx_q;
        by = y + scy_q;
        base = lcdc_q[tbpf_pkg::LCDC_MAP_HIGH] ? tbpf_pkg::MAP_HIGH_BASE
                                                : tbpf_pkg::MAP_LOW_BASE;
        return base + {3'b000, by[7:3], bx[7:3]};
    endfunction

    // low bitplane byte of the tile row under screen row y (high plane is the next byte)
    function automatic logic [12:0] tile_row_addr(logic [7:0] tile, logic [7:0] y);
        logic [7:0] by;
        by = y + scy_q;
        return {1'b0, tile, by[2:0], 1'b0};
    endfunction

    // expected result of a pixel fetch under the current registers
    function automatic pixel_t background_pixel(logic [7:0] x, logic [7:0] y);
        logic [7:0]  bx;
        logic [12:0] row;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [2:0]  sel;
        logic [1:0]  colour;
        pixel_t      p;
        p.x     = x;
        p.y     = y;
        p.shade = 2'd0;
        p.argb  = tbpf_pkg::ARGB_SHADE0;
        // white unless display, background and unsigned tile data are all on
        if (lcdc_q[tbpf_pkg::LCDC_DISPLAY_ON] && lcdc_q[tbpf_pkg::LCDC_BG_ON]
            && lcdc_q[tbpf_pkg::LCDC_TILE_UNSIGN])
        begin
            bx     = x + scx_q;
            row    = tile_row_addr(video_mem[map_entry_addr(x, y)], y);
            lo     = video_mem[row];
            hi     = video_mem[row | 13'd1];
            sel    = 3'd7 - bx[2:0];    // bit 7 is the leftmost pixel
            colour = {hi[sel], lo[sel]};
            p.shade = pal_q[2 * colour +: 2];
            p.argb  = shade_colour[p.shade];
        end
        return p;
    endfunction

    function automatic plan_row_t make_row(row_kind_t kind, logic [12:0] addr,
                                           logic [7:0] data, logic [7:0] x,
                                           logic [7:0] y, bit typed,
                                           logic [1:0] sh, logic [31:0] col);
        plan_row_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.data  = data;
        r.x     = x;
        r.y     = y;
        r.typed = typed;
        r.want  = {sh, col, x, y};
        return r;
    endfunction

    // scrolls and palette: the extremes often, anything else otherwise
    function automatic logic [7:0] biased_byte();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got);
        if (got !== want_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got);
            errors++;
        end
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // one request transfer: optional idle burst, then hold until accepted
    task automatic send_item(logic kind, logic [12:0] a, logic [7:0] d,
                             logic [7:0] x, logic [7:0] y, bit typed, pixel_t want);
        int gap;
        gap = (quiet || smooth || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        mem_addr  <= a;
        mem_data  <= d;
        pixel_x   <= x;
        pixel_y   <= y;
        do @(posedge clk); while (req_stall);
        // transfer taken at this edge, update the shadow in transfer order
        items_sent++;
        if (kind == tbpf_pkg::REQ_WRITE)
        begin
            video_mem[a]   = d;
            mem_written[a] = 1'b1;
        end
        else
            pending_pixels.push_back(typed ? want : background_pixel(x, y));
    endtask

    // memory write; the pixel position fields ride along with random content
    task automatic write_byte(logic [12:0] a, logic [7:0] d);
        send_item(tbpf_pkg::REQ_WRITE, a, d, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // pixel fetch; any byte the fetch would read that holds no data yet is
    // written first, so the block never reads unwritten memory
    task automatic fetch_pixel(logic [7:0] x, logic [7:0] y, bit typed, pixel_t want);
        logic [12:0] a;
        a = map_entry_addr(x, y);
        if (!mem_written[a])
            write_byte(a, 8'($urandom_range(0, 255)));
        a = tile_row_addr(video_mem[a], y);
        if (!mem_written[a])
            write_byte(a, 8'($urandom_range(0, 255)));
        if (!mem_written[a | 13'd1])
            write_byte(a | 13'd1, 8'($urandom_range(0, 255)));
        send_item(tbpf_pkg::REQ_PIXEL, 13'($urandom_range(0, 8191)),
                  8'($urandom_range(0, 255)), x, y, typed, want);
    endtask

    // sender pauses until every pixel has come back, then lets the pipe empty
    task automatic wait_for_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb register write: setup cycle, then access cycle
    task automatic apb_write(logic [1:0] idx, logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            tbpf_pkg::REG_LCD_CONTROL: lcdc_q = value;
            tbpf_pkg::REG_HSCROLL:     scx_q  = value;
            tbpf_pkg::REG_VSCROLL:     scy_q  = value;
            tbpf_pkg::REG_PALETTE:     pal_q  = value;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // result side: random stall bursts, checking, watchdog
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (quiet || smooth)
        begin
            res_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            res_stall <= 1'b1;
            stall_left = $urandom_range(0, 7);
        end
        else
            res_stall <= 1'b0;
    end

    // each result transfer against the oldest pending pixel
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result transfer with no fetch pending: out_x %0d out_y %0d",
                       out_x, out_y);
                errors++;
            end
            else
            begin
                oldest = pending_pixels.pop_front();
                check_field("shade", {30'd0, oldest.shade}, {30'd0, shade});
                check_field("argb", oldest.argb, argb);
                check_field("out_x", {24'd0, oldest.x}, {24'd0, out_x});
                check_field("out_y", {24'd0, oldest.y}, {24'd0, out_y});
            end
        end
    end

    // count cycles in which nothing moves on any port
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial
    begin
        plan_row_t  r;
        int         phase;
        int         run_len;
        int         choice;
        int         len;
        logic [7:0] x;
        logic [7:0] y;

        // after reset the display is off: white, even at the far corner
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd0, 8'd0, 1, 2'd0, tbpf_pkg::ARGB_SHADE0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd255, 8'd255, 1, 2'd0,
                                tbpf_pkg::ARGB_SHADE0));
        // address and data extremes
        plan.push_back(make_row(ROW_WRITE, 13'h0000, 8'h00, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_WRITE, 13'h1fff, 8'hff, 0, 0, 0, 0, 0));
        // display on, unsigned data, lower map; palette all black, then all white
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_LCD_CONTROL), 8'h91,
                                0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_PALETTE), 8'hff, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd159, 8'd143, 1, 2'd3,
                                tbpf_pkg::ARGB_SHADE3));
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_PALETTE), 8'h00, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd0, 8'd0, 1, 2'd0, tbpf_pkg::ARGB_SHADE0));
        // identity palette and a tile row holding all four colours, colour 0 included
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_PALETTE), 8'he4, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_WRITE, 13'h1800, 8'h02, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_WRITE, 13'h0020, 8'h33, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_WRITE, 13'h0021, 8'h0f, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd0, 8'd0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd2, 8'd0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd4, 8'd0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd7, 8'd0, 0, 0, 0));
        // full scroll wraps both sums back onto the same tile
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_HSCROLL), 8'hff, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_VSCROLL), 8'hff, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd1, 8'd1, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd255, 8'd255, 0, 0, 0));
        // every control bit set: upper map
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_LCD_CONTROL), 8'hff,
                                0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_WRITE, 13'h1c00, 8'h02, 0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd1, 8'd1, 0, 0, 0));
        // signed tile data, background off, display off: all white
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_LCD_CONTROL), 8'h89,
                                0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd3, 8'd3, 1, 2'd0, tbpf_pkg::ARGB_SHADE0));
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_LCD_CONTROL), 8'h90,
                                0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd3, 8'd3, 1, 2'd0, tbpf_pkg::ARGB_SHADE0));
        plan.push_back(make_row(ROW_CFG, 13'(tbpf_pkg::REG_LCD_CONTROL), 8'h11,
                                0, 0, 0, 0, 0));
        plan.push_back(make_row(ROW_PIXEL, 0, 0, 8'd3, 8'd3, 1, 2'd0, tbpf_pkg::ARGB_SHADE0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed plan
        foreach (plan[i])
        begin
            r = plan[i];
            case (r.kind)
                ROW_CFG:
                begin
                    wait_for_drain();
                    apb_write(r.addr[1:0], r.data);
                end
                ROW_WRITE: write_byte(r.addr, r.data);
                default:   fetch_pixel(r.x, r.y, r.typed, r.want);
            endcase
        end

        // random phases, each with fresh register settings
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            quiet  = items_sent >= QUIET_FROM;
            smooth = (phase % 3 == 2);
            wait_for_drain();
            // mostly a live background, sometimes any control value
            apb_write(tbpf_pkg::REG_LCD_CONTROL, ($urandom_range(0, 9) < 7) ?
                      (8'($urandom_range(0, 255)) | 8'h91) : 8'($urandom_range(0, 255)));
            apb_write(tbpf_pkg::REG_HSCROLL, biased_byte());
            apb_write(tbpf_pkg::REG_VSCROLL, biased_byte());
            apb_write(tbpf_pkg::REG_PALETTE, biased_byte());

            run_len = $urandom_range(60, 140);
            for (int n = 0; n < run_len && items_sent < ITEM_TARGET; n++)
            begin
                quiet = items_sent >= QUIET_FROM;
                // mid phase the sender holds off until every pixel is back
                if (n == run_len / 2)
                    wait_for_drain();
                choice = $urandom_range(0, 99);
                if (choice < 35)
                begin
                    // writes favor the tile maps and tile data
                    case ($urandom_range(0, 4))
                        0, 1:    x = 8'd0;
                        default: x = 8'd1;
                    endcase
                    if ($urandom_range(0, 4) == 0)
                        write_byte(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
                    else if (x == 8'd0)
                        write_byte(tbpf_pkg::MAP_LOW_BASE + 13'($urandom_range(0, 2047)),
                                   8'($urandom_range(0, 255)));
                    else
                        write_byte(13'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
                end
                else if (choice < 50)
                begin
                    // a short stretch of one scan line, as a display would request it
                    x   = 8'($urandom_range(0, 159));
                    y   = 8'($urandom_range(0, 143));
                    len = $urandom_range(8, 24);
                    for (int k = 0; k < len; k++)
                        fetch_pixel(x + 8'(k), y, 1'b0, '0);
                end
                else
                begin
                    // mostly on screen, sometimes anywhere the fields allow
                    x = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 159));
                    y = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 143));
                    fetch_pixel(x, y, 1'b0, '0);
                end
            end
            phase++;
        end

        // let every pixel come back and the pipe go quiet
        wait_for_drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
